// File: src/wvc_pkg.sv
package wvc_pkg;

   // store geometry
   localparam int MAX_DIMS    = 4;
   localparam int MAX_CLASSES = 16;
   localparam int STORE_SLOTS = 64;
   localparam int ADDR_W      = $clog2(STORE_SLOTS);
   localparam int SLOT_W      = $clog2(STORE_SLOTS + MAX_DIMS * MAX_CLASSES) + 1;
   localparam int CLS_W       = $clog2(MAX_CLASSES) + 1;
   localparam int K_W         = CLS_W - 1;

   // field widths
   localparam int OPCODE_W   = 2;
   localparam int WEIGHT_W   = 17;
   localparam int DIM_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int CLASS_W    = 4;
   localparam int SCORE_W    = 40;
   localparam int MEAN_W     = 40;
   localparam int VAR_W      = 64;
   localparam int DIMS_REG_W = 3;
   localparam int CLS_REG_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int CLS_IDX_W  = 7;

   typedef logic signed [63:0] acc_type;
   typedef logic signed [64:0] wide_type;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_VOTE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TALLY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIMS_IN_USE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLASSES_DIM0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLASSES_DIM1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLASSES_DIM2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLASSES_DIM3 = 3'd4;

   // saturation bounds
   localparam wide_type CAT_MAX = 65'h0_0000_00FF_FFFF_FFFF;
   localparam wide_type M40_MAX = 65'h0_0000_007F_FFFF_FFFF;
   localparam wide_type M40_MIN = 65'h1_FFFF_FF80_0000_0000;
   localparam wide_type S64_MAX = 65'h0_7FFF_FFFF_FFFF_FFFF;
   localparam wide_type ZERO    = 65'h0;

endpackage

// File: src/wvc_csr_if.sv
interface wvc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [wvc_pkg::CSR_IDX_W-1:0]    index;
   logic [wvc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/wvc_req_if.sv
interface wvc_req_if;
   logic                                valid;
   logic                                ready;
   logic [wvc_pkg::OPCODE_W-1:0]        opcode;
   logic [wvc_pkg::WEIGHT_W-1:0]        vote_weight;
   logic [wvc_pkg::DIM_W-1:0]           dim_index;
   logic signed [wvc_pkg::VALUE_W-1:0]  predicted_value;

   modport source (output valid, output opcode, output vote_weight, output dim_index,
                   output predicted_value, input ready);
   modport sink (input valid, input opcode, input vote_weight, input dim_index,
                 input predicted_value, output ready);
endinterface

// File: src/wvc_rsp_if.sv
interface wvc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [wvc_pkg::DIM_W-1:0]          result_dim;
   logic                               is_categorical;
   logic [wvc_pkg::CLASS_W-1:0]        winning_class;
   logic [wvc_pkg::SCORE_W-1:0]        winning_score;
   logic signed [wvc_pkg::MEAN_W-1:0]  mean_value;
   logic signed [wvc_pkg::VAR_W-1:0]   variance_value;
   logic                               last_result;

   modport source (output valid, output result_dim, output is_categorical,
                   output winning_class, output winning_score, output mean_value,
                   output variance_value, output last_result, input ready);
   modport sink (input valid, input result_dim, input is_categorical,
                 input winning_class, input winning_score, input mean_value,
                 input variance_value, input last_result, output ready);
endinterface

// File: src/weighted_vote_combiner.sv
// clear and unknown ops finish in idle; a categorical vote reads and writes one slot, a
// continuous vote does a read-modify-write of two slots through one shared 33x33 multiplier
// tally: a categorical dimension reads one slot a cycle for the argmax, a continuous
// dimension takes five partial products from the shared multiplier for the mean square
// one item at a time; results leave through an output register, so a new item is taken
// while the last result waits. reset clears config to defaults and every slot reads zero
module weighted_vote_combiner (
   input  logic               clock,
   input  logic               reset,
   wvc_csr_if.sink            csr_ch,
   wvc_req_if.sink            req_ch,
   wvc_rsp_if.source          rsp_ch
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_VK_RD  = 4'd1;
   localparam logic [3:0] ST_VK_WR  = 4'd2;
   localparam logic [3:0] ST_VC_RD  = 4'd3;
   localparam logic [3:0] ST_VC_WR0 = 4'd4;
   localparam logic [3:0] ST_VC_RD1 = 4'd5;
   localparam logic [3:0] ST_VC_WR1 = 4'd6;
   localparam logic [3:0] ST_TD     = 4'd7;
   localparam logic [3:0] ST_TK     = 4'd8;
   localparam logic [3:0] ST_TM     = 4'd9;
   localparam logic [3:0] ST_SQ     = 4'd10;
   localparam logic [3:0] ST_TOUT   = 4'd11;

   // control registers
   logic [3:0]                           state_ff, state_in;
   logic [wvc_pkg::DIMS_REG_W-1:0]       dims_ff, dims_in;
   logic [wvc_pkg::CLS_REG_W-1:0]        classes_ff [wvc_pkg::MAX_DIMS];
   logic [wvc_pkg::CLS_REG_W-1:0]        classes_in [wvc_pkg::MAX_DIMS];
   logic [wvc_pkg::STORE_SLOTS-1:0]      valid_ff, valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // store
   wvc_pkg::acc_type                     vote_store_ff [wvc_pkg::STORE_SLOTS];
   wvc_pkg::acc_type                     rdata_ff;
   logic                                 rvalid_ff;

   // datapath registers
   logic [63:0]                          prod_ff, prod_in;
   logic [wvc_pkg::WEIGHT_W-1:0]         w_ff, w_in;
   logic signed [wvc_pkg::VALUE_W-1:0]   x_ff, x_in;
   logic [wvc_pkg::SLOT_W-1:0]           slot_ff, slot_in;
   logic [wvc_pkg::SLOT_W-1:0]           rptr_ff, rptr_in;
   logic [wvc_pkg::DIM_W-1:0]            dim_ff, dim_in;
   logic [wvc_pkg::K_W-1:0]              k_ff, k_in;
   logic [wvc_pkg::K_W-1:0]              best_ff, best_in;
   wvc_pkg::acc_type                     bv_ff, bv_in;
   wvc_pkg::acc_type                     mean_ff, mean_in;
   logic [63:0]                          am_ff, am_in;
   wvc_pkg::acc_type                     m2_ff, m2_in;
   logic [63:0]                          acc_ff, acc_in;
   logic [2:0]                           step_ff, step_in;

   // output register
   logic [wvc_pkg::DIM_W-1:0]            rsp_dim_ff, rsp_dim_in;
   logic                                 rsp_cat_ff, rsp_cat_in;
   logic [wvc_pkg::CLASS_W-1:0]          rsp_class_ff, rsp_class_in;
   logic [wvc_pkg::SCORE_W-1:0]          rsp_score_ff, rsp_score_in;
   logic signed [wvc_pkg::MEAN_W-1:0]    rsp_mean_ff, rsp_mean_in;
   logic signed [wvc_pkg::VAR_W-1:0]     rsp_var_ff, rsp_var_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // layout
   logic [wvc_pkg::CLS_W-1:0]            cnt [wvc_pkg::MAX_DIMS];
   logic [wvc_pkg::CLS_W-1:0]            span [wvc_pkg::MAX_DIMS];
   logic [wvc_pkg::SLOT_W-1:0]           base [wvc_pkg::MAX_DIMS];
   logic [wvc_pkg::DIMS_REG_W-1:0]       nd;
   logic [wvc_pkg::CLS_W-1:0]            req_cnt, cur_cnt;
   logic [wvc_pkg::CLS_IDX_W-1:0]        cls_idx;
   logic                                 cls_ok;

   // shared units
   logic signed [32:0]                   mul_a, mul_b;
   logic signed [65:0]                   mul_p;
   wvc_pkg::acc_type                     rd_val, add_v, add_res;
   wvc_pkg::wide_type                    add_lo, add_hi, add_sum;
   logic [wvc_pkg::SLOT_W-1:0]           rd_addr;
   logic                                 wr_en;
   logic                                 req_fire;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_dim     = rsp_dim_ff;
   assign rsp_ch.is_categorical = rsp_cat_ff;
   assign rsp_ch.winning_class  = rsp_class_ff;
   assign rsp_ch.winning_score  = rsp_score_ff;
   assign rsp_ch.mean_value     = rsp_mean_ff;
   assign rsp_ch.variance_value = rsp_var_ff;
   assign rsp_ch.last_result    = rsp_last_ff;

   // class counts and prefix-summed slot bases
   always_comb begin
      for (int i = 0; i < wvc_pkg::MAX_DIMS; i++) begin
         cnt[i] = (wvc_pkg::CLS_W'(classes_ff[i]) > wvc_pkg::CLS_W'(wvc_pkg::MAX_CLASSES)) ?
                  wvc_pkg::CLS_W'(wvc_pkg::MAX_CLASSES) : wvc_pkg::CLS_W'(classes_ff[i]);
         span[i] = (cnt[i] == '0) ? wvc_pkg::CLS_W'(2) : cnt[i];
      end
      base[0] = '0;
      for (int i = 1; i < wvc_pkg::MAX_DIMS; i++) begin
         base[i] = base[i-1] + wvc_pkg::SLOT_W'(span[i-1]);
      end
      if (dims_ff == '0) begin
         nd = wvc_pkg::DIMS_REG_W'(1);
      end else if (dims_ff > wvc_pkg::DIMS_REG_W'(wvc_pkg::MAX_DIMS)) begin
         nd = wvc_pkg::DIMS_REG_W'(wvc_pkg::MAX_DIMS);
      end else begin
         nd = dims_ff;
      end
      req_cnt = cnt[req_ch.dim_index];
      cur_cnt = cnt[dim_ff];
   end

   // class index: integer part truncated toward zero, negatives of -1 and below dropped
   always_comb begin
      cls_idx = '0;
      cls_ok  = 1'b0;
      if (!req_ch.predicted_value[15]) begin
         cls_idx = req_ch.predicted_value[14:8];
         cls_ok  = cls_idx < wvc_pkg::CLS_IDX_W'(req_cnt);
      end else if (req_ch.predicted_value[15:8] == 8'hFF &&
                   req_ch.predicted_value[7:0] != 8'h00) begin
         cls_ok = (req_cnt != '0);
      end
   end

   assign rd_val = rvalid_ff ? rdata_ff : '0;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_VC_RD: begin
            mul_a = {{17{x_ff[15]}}, x_ff};
            mul_b = {16'b0, w_ff};
         end
         ST_VC_WR0: begin
            mul_a = {{17{x_ff[15]}}, x_ff};
            mul_b = {{17{x_ff[15]}}, x_ff};
         end
         ST_VC_RD1: begin
            mul_a = {16'b0, w_ff};
            mul_b = $signed(prod_ff[32:0]);
         end
         ST_SQ: begin
            // mean square from 20-bit split: hi*hi, hi*lo, lo*lo with hi in two parts
            unique case (step_ff)
               3'd0: begin
                  mul_a = {1'b0, am_ff[51:20]};
                  mul_b = {1'b0, am_ff[51:20]};
               end
               3'd1: begin
                  mul_a = {1'b0, am_ff[51:20]};
                  mul_b = {21'b0, am_ff[63:52]};
               end
               3'd2: begin
                  mul_a = {1'b0, am_ff[51:20]};
                  mul_b = {13'b0, am_ff[19:0]};
               end
               3'd3: begin
                  mul_a = {21'b0, am_ff[63:52]};
                  mul_b = {13'b0, am_ff[19:0]};
               end
               3'd4: begin
                  mul_a = {13'b0, am_ff[19:0]};
                  mul_b = {13'b0, am_ff[19:0]};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p   = mul_a * mul_b;
      prod_in = mul_p[63:0];
   end

   // shared saturating accumulate
   always_comb begin
      unique case (state_ff)
         ST_VC_WR0: begin
            add_v  = $signed(prod_ff);
            add_lo = wvc_pkg::M40_MIN;
            add_hi = wvc_pkg::M40_MAX;
         end
         ST_VC_WR1: begin
            add_v  = $signed(prod_ff);
            add_lo = wvc_pkg::ZERO;
            add_hi = wvc_pkg::S64_MAX;
         end
         default: begin
            add_v  = $signed({47'b0, w_ff});
            add_lo = wvc_pkg::ZERO;
            add_hi = wvc_pkg::CAT_MAX;
         end
      endcase
      add_sum = {rd_val[63], rd_val} + {add_v[63], add_v};
      priority if (add_sum > add_hi) begin
         add_res = add_hi[63:0];
      end else if (add_sum < add_lo) begin
         add_res = add_lo[63:0];
      end else begin
         add_res = add_sum[63:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_TD:          rd_addr = base[dim_ff];
         ST_TK, ST_TM:   rd_addr = rptr_ff;
         default:        rd_addr = slot_ff;
      endcase
   end

   assign wr_en = (state_ff == ST_VK_WR || state_ff == ST_VC_WR0 || state_ff == ST_VC_WR1) &&
                  (slot_ff < wvc_pkg::SLOT_W'(wvc_pkg::STORE_SLOTS));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dims_in      = dims_ff;
      classes_in   = classes_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      w_in         = w_ff;
      x_in         = x_ff;
      slot_in      = slot_ff;
      rptr_in      = rptr_ff;
      dim_in       = dim_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      bv_in        = bv_ff;
      mean_in      = mean_ff;
      am_in        = am_ff;
      m2_in        = m2_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      rsp_dim_in   = rsp_dim_ff;
      rsp_cat_in   = rsp_cat_ff;
      rsp_class_in = rsp_class_ff;
      rsp_score_in = rsp_score_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            wvc_pkg::REG_DIMS_IN_USE:  dims_in       = csr_ch.data[wvc_pkg::DIMS_REG_W-1:0];
            wvc_pkg::REG_CLASSES_DIM0: classes_in[0] = csr_ch.data;
            wvc_pkg::REG_CLASSES_DIM1: classes_in[1] = csr_ch.data;
            wvc_pkg::REG_CLASSES_DIM2: classes_in[2] = csr_ch.data;
            wvc_pkg::REG_CLASSES_DIM3: classes_in[3] = csr_ch.data;
            default: ;
         endcase
      end

      if (wr_en) begin
         valid_in[slot_ff[wvc_pkg::ADDR_W-1:0]] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.opcode)
                  wvc_pkg::OP_CLEAR: valid_in = '0;
                  wvc_pkg::OP_VOTE: begin
                     w_in = req_ch.vote_weight;
                     x_in = req_ch.predicted_value;
                     if (wvc_pkg::DIMS_REG_W'(req_ch.dim_index) < nd) begin
                        if (req_cnt != '0) begin
                           if (cls_ok) begin
                              slot_in  = base[req_ch.dim_index] +
                                         wvc_pkg::SLOT_W'(cls_idx);
                              state_in = ST_VK_RD;
                           end
                        end else begin
                           slot_in  = base[req_ch.dim_index];
                           state_in = ST_VC_RD;
                        end
                     end
                  end
                  wvc_pkg::OP_TALLY: begin
                     dim_in   = '0;
                     state_in = ST_TD;
                  end
                  default: ;
               endcase
            end
         end
         ST_VK_RD:  state_in = ST_VK_WR;
         ST_VK_WR:  state_in = ST_IDLE;
         ST_VC_RD:  state_in = ST_VC_WR0;
         ST_VC_WR0: begin
            slot_in  = slot_ff + wvc_pkg::SLOT_W'(1);
            state_in = ST_VC_RD1;
         end
         ST_VC_RD1: state_in = ST_VC_WR1;
         ST_VC_WR1: state_in = ST_IDLE;
         ST_TD: begin
            rptr_in = base[dim_ff] + wvc_pkg::SLOT_W'(1);
            k_in    = '0;
            state_in = (cur_cnt != '0) ? ST_TK : ST_TM;
         end
         ST_TK: begin
            // slot k of the dimension arrives; strict compare keeps lowest index on ties
            if (k_ff == '0 || rd_val > bv_ff) begin
               bv_in   = rd_val;
               best_in = k_ff;
            end
            rptr_in = rptr_ff + wvc_pkg::SLOT_W'(1);
            k_in    = k_ff + wvc_pkg::K_W'(1);
            if (wvc_pkg::CLS_W'(k_ff) == cur_cnt - wvc_pkg::CLS_W'(1)) begin
               state_in = ST_TOUT;
            end
         end
         ST_TM: begin
            mean_in  = rd_val;
            am_in    = rd_val[63] ? (~rd_val + 64'd1) : rd_val;
            acc_in   = '0;
            step_in  = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (step_ff == 3'd0) begin
               m2_in = rd_val;
            end
            // fold in the product issued one step earlier
            unique case (step_ff)
               3'd1:    acc_in = acc_ff + (prod_ff << 24);
               3'd2:    acc_in = acc_ff + (prod_ff << 57);
               3'd3:    acc_in = acc_ff + (prod_ff << 5);
               3'd4:    acc_in = acc_ff + (prod_ff << 37);
               3'd5:    acc_in = acc_ff + (prod_ff >> 16);
               default: acc_in = acc_ff;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = ST_TOUT;
            end
         end
         ST_TOUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dim_in   = dim_ff;
               rsp_last_in  = (wvc_pkg::DIMS_REG_W'(dim_ff) == nd - wvc_pkg::DIMS_REG_W'(1));
               if (cur_cnt != '0) begin
                  rsp_cat_in   = 1'b1;
                  rsp_class_in = best_ff;
                  rsp_score_in = bv_ff[wvc_pkg::SCORE_W-1:0];
                  rsp_mean_in  = '0;
                  rsp_var_in   = '0;
               end else begin
                  rsp_cat_in   = 1'b0;
                  rsp_class_in = '0;
                  rsp_score_in = '0;
                  rsp_mean_in  = mean_ff[wvc_pkg::MEAN_W-1:0];
                  rsp_var_in   = m2_ff - $signed(acc_ff);
               end
               dim_in = dim_ff + wvc_pkg::DIM_W'(1);
               if (wvc_pkg::DIMS_REG_W'(dim_ff) == nd - wvc_pkg::DIMS_REG_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_TD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= wvc_pkg::DIMS_REG_W'(1);
         for (int i = 0; i < wvc_pkg::MAX_DIMS; i++) begin
            classes_ff[i] <= '0;
         end
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dims_ff      <= dims_in;
         classes_ff   <= classes_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      w_ff         <= w_in;
      x_ff         <= x_in;
      slot_ff      <= slot_in;
      rptr_ff      <= rptr_in;
      dim_ff       <= dim_in;
      k_ff         <= k_in;
      best_ff      <= best_in;
      bv_ff        <= bv_in;
      mean_ff      <= mean_in;
      am_ff        <= am_in;
      m2_ff        <= m2_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      rsp_dim_ff   <= rsp_dim_in;
      rsp_cat_ff   <= rsp_cat_in;
      rsp_class_ff <= rsp_class_in;
      rsp_score_ff <= rsp_score_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // accumulator memory, registered read; an unwritten slot reads zero through its valid bit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vote_store_ff[slot_ff[wvc_pkg::ADDR_W-1:0]] <= add_res;
      end
      rdata_ff  <= vote_store_ff[rd_addr[wvc_pkg::ADDR_W-1:0]];
      rvalid_ff <= (rd_addr < wvc_pkg::SLOT_W'(wvc_pkg::STORE_SLOTS)) &&
                   valid_ff[rd_addr[wvc_pkg::ADDR_W-1:0]];
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import wvc_pkg::*;

   localparam logic [OPCODE_W-1:0]  OP_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO  = REG_CLASSES_DIM3 + 3'd1;
   localparam int                   HOLD_CYCLES   = 400;
   localparam int                   SETTLE_CYCLES = 100;
   localparam int                   RANDOM_ITEMS  = 220;
   localparam int                   RUN_LIMIT_NS  = 4_000_000;

   typedef struct {
      logic [DIM_W-1:0]          result_dim;
      logic                      is_categorical;
      logic [CLASS_W-1:0]        winning_class;
      logic [SCORE_W-1:0]        winning_score;
      logic signed [MEAN_W-1:0]  mean_value;
      logic signed [VAR_W-1:0]   variance_value;
      logic                      last_result;
   } tally_row_t;

   class vote_tally_board;
      acc_type           slots[STORE_SLOTS];
      logic [2:0]        dims_reg;
      logic [4:0]        class_reg[MAX_DIMS];
      tally_row_t        awaited_rows[$];
      int                errors;

      function new();
         foreach (slots[i]) slots[i] = '0;
         dims_reg = 3'd1;
         foreach (class_reg[i]) class_reg[i] = '0;
         errors = 0;
      endfunction

      task report(string what);
         if (errors < 100) $display("mismatch: %s", what);
         errors++;
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_DIMS_IN_USE: dims_reg = data[2:0];
            REG_CLASSES_DIM0, REG_CLASSES_DIM1, REG_CLASSES_DIM2, REG_CLASSES_DIM3:
               class_reg[idx - REG_CLASSES_DIM0] = data;
            default: ;
         endcase
      endfunction

      function int active_dims();
         int d;
         d = dims_reg;
         if (d == 0) d = 1;
         if (d > MAX_DIMS) d = MAX_DIMS;
         return d;
      endfunction

      function int classes_of(int d);
         int n;
         n = class_reg[d & 3];
         if (n > MAX_CLASSES) n = MAX_CLASSES;
         return n;
      endfunction

      function int base_of(int d);
         int b;
         b = 0;
         for (int k = 0; k < d; k++) b += (classes_of(k) == 0) ? 2 : classes_of(k);
         return b;
      endfunction

      function acc_type slot_read(int s);
         return (s < STORE_SLOTS) ? slots[s] : acc_type'(0);
      endfunction

      function void acc_add(int s, acc_type v, acc_type lo, acc_type hi);
         acc_type r;
         if (s >= STORE_SLOTS) return;
         r = slots[s];
         if (v > 0 && r > hi - v) r = hi;
         else if (v < 0 && r < lo - v) r = lo;
         else r = r + v;
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         slots[s] = r;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [WEIGHT_W-1:0] w,
                                 logic [DIM_W-1:0] d, logic [VALUE_W-1:0] x);
         acc_type      wv, xv, mean, m2, bv, v;
         logic [127:0] am, sq_full;
         int           nd, n, base, idx, best;
         tally_row_t   row;
         nd = active_dims();
         wv = w;
         xv = $signed(x);
         case (op)
            OP_CLEAR: foreach (slots[i]) slots[i] = '0;
            OP_VOTE: begin
               if (d < nd) begin
                  base = base_of(d);
                  n = classes_of(d);
                  if (n > 0) begin
                     // truncation toward zero: (-1,0) lands on class 0
                     if (xv >= 0) idx = int'(xv >>> 8);
                     else idx = (((-xv) >>> 8) == 0) ? 0 : -1;
                     if (idx >= 0 && idx < n)
                        acc_add(base + idx, wv, acc_type'(ZERO), acc_type'(CAT_MAX));
                  end else begin
                     acc_add(base, wv * xv, acc_type'(M40_MIN), acc_type'(M40_MAX));
                     acc_add(base + 1, wv * (xv * xv), acc_type'(ZERO), acc_type'(S64_MAX));
                  end
               end
            end
            OP_TALLY: begin
               base = 0;
               for (int k = 0; k < nd; k++) begin
                  n = classes_of(k);
                  row.result_dim = DIM_W'(k);
                  row.last_result = (k + 1 == nd);
                  if (n > 0) begin
                     best = 0;
                     bv = slot_read(base);
                     for (int c = 1; c < n; c++) begin
                        v = slot_read(base + c);
                        if (v > bv) begin
                           bv = v;
                           best = c;
                        end
                     end
                     row.is_categorical = 1'b1;
                     row.winning_class = CLASS_W'(best);
                     row.winning_score = bv[SCORE_W-1:0];
                     row.mean_value = '0;
                     row.variance_value = '0;
                     base += n;
                  end else begin
                     mean = slot_read(base);
                     m2 = slot_read(base + 1);
                     am = (mean < 0) ? -mean : mean;
                     sq_full = am * am;
                     row.is_categorical = 1'b0;
                     row.winning_class = '0;
                     row.winning_score = '0;
                     row.mean_value = mean[MEAN_W-1:0];
                     row.variance_value = m2 - sq_full[79:16];
                     base += 2;
                  end
                  awaited_rows.push_back(row);
               end
            end
            default: ;
         endcase
      endfunction

      task check_row(tally_row_t got);
         tally_row_t want;
         if (awaited_rows.size() == 0) begin
            report($sformatf("result for dim %0d with none pending", got.result_dim));
            return;
         end
         want = awaited_rows.pop_front();
         if (got.result_dim !== want.result_dim)
            report($sformatf("result_dim %0d, want %0d", got.result_dim, want.result_dim));
         if (got.is_categorical !== want.is_categorical)
            report($sformatf("dim %0d is_categorical %0b, want %0b", want.result_dim,
                             got.is_categorical, want.is_categorical));
         if (got.winning_class !== want.winning_class)
            report($sformatf("dim %0d winning_class %0d, want %0d", want.result_dim,
                             got.winning_class, want.winning_class));
         if (got.winning_score !== want.winning_score)
            report($sformatf("dim %0d winning_score %h, want %h", want.result_dim,
                             got.winning_score, want.winning_score));
         if (got.mean_value !== want.mean_value)
            report($sformatf("dim %0d mean_value %h, want %h", want.result_dim,
                             got.mean_value, want.mean_value));
         if (got.variance_value !== want.variance_value)
            report($sformatf("dim %0d variance_value %h, want %h", want.result_dim,
                             got.variance_value, want.variance_value));
         if (got.last_result !== want.last_result)
            report($sformatf("dim %0d last_result %0b, want %0b", want.result_dim,
                             got.last_result, want.last_result));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   burst_mode = 1'b0;
   bit   hold_rsp = 1'b0;
   int   items_sent = 0;

   vote_tally_board tally_board;

   wvc_csr_if csr_bus ();
   wvc_req_if req_bus ();
   wvc_rsp_if rsp_bus ();

   weighted_vote_combiner uut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_bus),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_classes();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 2) return '0;
      if (r == 3) return 5'd1;
      if (r == 4) return 5'(MAX_CLASSES);
      if (r == 5) return 5'($urandom_range(MAX_CLASSES + 1, 31));
      return 5'($urandom_range(2, MAX_CLASSES - 1));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_dims();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 5'($urandom_range(MAX_DIMS + 1, 7));
      if (r == 2) return 5'(MAX_DIMS);
      if (r == 3) return 5'd1;
      return 5'($urandom_range(1, MAX_DIMS));
   endfunction

   // valid stays high after acceptance; wait_idle lowers it, the next call only before a gap
   task automatic send_req(logic [OPCODE_W-1:0] op, logic [WEIGHT_W-1:0] w,
                           logic [DIM_W-1:0] d, logic [VALUE_W-1:0] x);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.vote_weight <= w;
      req_bus.dim_index <= d;
      req_bus.predicted_value <= x;
      do @(posedge clock); while (!req_bus.ready);
      tally_board.note_request(op, w, d, x);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // an op whose other fields are don't-care
   task automatic send_op(logic [OPCODE_W-1:0] op);
      send_req(op, 17'($urandom), 2'($urandom), 16'($urandom));
   endtask

   task automatic random_vote();
      logic [DIM_W-1:0]    d;
      logic [WEIGHT_W-1:0] w;
      logic [VALUE_W-1:0]  x;
      int                  n, r;
      if ($urandom_range(0, 9) != 0) d = 2'($urandom_range(0, tally_board.active_dims() - 1));
      else d = 2'($urandom);
      n = tally_board.classes_of(d);
      r = $urandom_range(0, 9);
      if (r == 0) w = '0;
      else if (r == 1) w = 17'h10000;
      else if (r == 2) w = 17'h0FFFF;
      else w = 17'($urandom_range(0, 65536));
      r = $urandom_range(0, 9);
      if (n > 0 && r < 7) x = {8'($urandom_range(0, n - 1)), 8'($urandom)};
      else if (n > 0 && r == 7) x = {8'hFF, 8'($urandom_range(1, 255))};
      else if (r == 8) x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      else x = 16'($urandom);
      send_req(OP_VOTE, w, d, x);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (tally_board.awaited_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      tally_board.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] dims, logic [CSR_DATA_W-1:0] c0,
                             logic [CSR_DATA_W-1:0] c1, logic [CSR_DATA_W-1:0] c2,
                             logic [CSR_DATA_W-1:0] c3);
      wait_idle();
      csr_write(REG_DIMS_IN_USE, dims);
      csr_write(REG_CLASSES_DIM0, c0);
      csr_write(REG_CLASSES_DIM1, c1);
      csr_write(REG_CLASSES_DIM2, c2);
      csr_write(REG_CLASSES_DIM3, c3);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic vote_sequence();
      int votes, r;
      votes = $urandom_range(2, 14);
      repeat (votes) begin
         r = $urandom_range(0, 19);
         if (r == 0) send_op(OP_UNUSED);
         else if (r == 1) send_op(OP_TALLY);
         else if (r == 2) send_op(OP_CLEAR);
         else random_vote();
      end
      send_op(OP_TALLY);
   endtask

   task automatic random_phase();
      int seqs;
      set_config(random_dims(), random_classes(), random_classes(), random_classes(),
                 random_classes());
      burst_mode = ($urandom_range(0, 4) == 0);
      // sometimes no clear, so old slots are read under the new layout
      if ($urandom_range(0, 4) != 0) send_op(OP_CLEAR);
      seqs = $urandom_range(1, 3);
      repeat (seqs) begin
         vote_sequence();
         if ($urandom_range(0, 3) == 0) wait_idle();
      end
      burst_mode = 1'b0;
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      int         stall_left;
      tally_row_t row;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            row.result_dim = rsp_bus.result_dim;
            row.is_categorical = rsp_bus.is_categorical;
            row.winning_class = rsp_bus.winning_class;
            row.winning_score = rsp_bus.winning_score;
            row.mean_value = rsp_bus.mean_value;
            row.variance_value = rsp_bus.variance_value;
            row.last_result = rsp_bus.last_result;
            tally_board.check_row(row);
         end
         @(negedge clock);
         if (hold_rsp) begin
            stall_left = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (burst_mode || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("** weighted_vote_combiner: FAILED **");
      $finish;
   end

   initial begin
      int start_count;
      tally_board = new();
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_CLEAR;
      req_bus.vote_weight = '0;
      req_bus.dim_index = '0;
      req_bus.predicted_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_DIMS_IN_USE;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: mixed layout, 3 / continuous / 16 / 1 classes
      set_config(5'd4, 5'd3, 5'd0, 5'd16, 5'd1);
      send_op(OP_TALLY);
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'h0200);
      send_req(OP_VOTE, 17'h00000, 2'd0, 16'h0100);
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'h0300);   // class past the count
      send_req(OP_VOTE, 17'h00001, 2'd0, 16'hFF80);   // -0.5 truncates to class 0
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'hFF00);   // negative class
      send_req(OP_VOTE, 17'h10000, 2'd1, 16'h7FFF);
      send_req(OP_VOTE, 17'h10000, 2'd1, 16'h8000);
      send_req(OP_VOTE, 17'd12345, 2'd1, 16'h0000);
      send_req(OP_VOTE, 17'h0FFFF, 2'd2, 16'h0F80);
      send_req(OP_VOTE, 17'h10000, 2'd2, 16'h1000);
      send_req(OP_VOTE, 17'd100,   2'd3, 16'h00FF);
      send_op(OP_UNUSED);
      send_op(OP_TALLY);
      send_op(OP_CLEAR);
      send_op(OP_TALLY);
      send_req(OP_VOTE, 17'd500, 2'd2, 16'h0400);     // tie goes to the lower class
      send_req(OP_VOTE, 17'd500, 2'd2, 16'h0900);
      send_op(OP_TALLY);

      // zero dims means one, class count clamps at the maximum
      set_config(5'd0, 5'd31, 5'd0, 5'd0, 5'd0);
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'h0F00);
      send_req(OP_VOTE, 17'h10000, 2'd1, 16'h0100);   // unused dimension
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'h1100);
      send_op(OP_TALLY);

      // dims above the maximum, spare register indexes, no clear
      set_config(5'd7, 5'd0, 5'd0, 5'd17, 5'd2);
      for (int i = REG_SPARE_LO; i < (1 << CSR_IDX_W); i++)
         csr_write(CSR_IDX_W'(i), 5'($urandom));
      csr_bus.valid <= 1'b0;
      send_op(OP_TALLY);

      // drive the first moment to both rails
      set_config(5'd1, 5'd0, 5'd0, 5'd0, 5'd0);
      send_op(OP_CLEAR);
      burst_mode = 1'b1;
      repeat (280) send_req(OP_VOTE, 17'h10000, 2'd0, 16'h8000);
      send_op(OP_TALLY);
      repeat (540) send_req(OP_VOTE, 17'h10000, 2'd0, 16'h7FFF);
      send_op(OP_TALLY);
      burst_mode = 1'b0;
      // view the moments as class slots; the second moment saturates the class
      set_config(5'd2, 5'd16, 5'd0, 5'd0, 5'd0);
      send_op(OP_TALLY);
      send_req(OP_VOTE, 17'd1, 2'd0, 16'h0100);
      send_req(OP_VOTE, 17'h10000, 2'd0, 16'h0000);
      send_op(OP_TALLY);

      // receiver holds off while tallies keep coming
      set_config(5'd4, 5'd2, 5'd0, 5'd5, 5'd0);
      send_op(OP_CLEAR);
      repeat (8) random_vote();
      burst_mode = 1'b1;
      hold_rsp = 1'b1;
      repeat (8) send_op(OP_TALLY);
      burst_mode = 1'b0;
      wait_idle();

      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) random_phase();

      wait_idle();
      if (tally_board.errors == 0 && tally_board.awaited_rows.size() == 0)
         $display("** weighted_vote_combiner: PASSED **");
      else
         $display("** weighted_vote_combiner: FAILED **");
      $finish;
   end

endmodule

// File: weighted_vote_combiner.f
src/wvc_pkg.sv
src/wvc_csr_if.sv
src/wvc_req_if.sv
src/wvc_rsp_if.sv
src/weighted_vote_combiner.sv
dv/tb_top.sv
